// File: rtl/lfu_pkg.sv
package lfu_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 32;
    localparam int STAMP_W = 48;
    localparam int CAP_W   = 5;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             cmd;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, clear scan results
        logic scan;      // examine the entry at the scan index
        logic write;     // apply the update for the captured request
        logic resp;      // load the response register
    } lfu_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic rsp_full;
    } lfu_status_t;

endpackage

// File: rtl/lfu_if.sv
interface lfu_req_if;
    import lfu_pkg::*;
    logic valid;
    logic ready;
    logic cmd;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
    modport source (output valid, cmd, key, value, input ready);
    modport sink (input valid, cmd, key, value, output ready);
endinterface

interface lfu_rsp_if;
    import lfu_pkg::*;
    logic valid;
    logic ready;
    logic hit;
    logic signed [VAL_W-1:0] read_value;
    modport source (output valid, hit, read_value, input ready);
    modport sink (input valid, hit, read_value, output ready);
endinterface

// File: rtl/lfu_ctrl.sv
module lfu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  lfu_pkg::lfu_status_t status,
    output lfu_pkg::lfu_cmd_t    ctl
);
    import lfu_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0] state_reg, state_next;

    assign req_ready = (state_reg == ST_IDLE) && !status.rsp_full;

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    ctl.load = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctl.scan = 1'b1;
                if (status.scan_last)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                ctl.write = 1'b1;
                ctl.resp = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_scan_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.write |=> state_reg == ST_IDLE)
        else $error("write not followed by idle");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> !req_ready)
        else $error("ready while busy");
    a_resp_with_write: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.resp == ctl.write)
        else $error("response without update");
endmodule

// File: rtl/lfu_datapath.sv
module lfu_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lfu_pkg::lfu_cmd_t        ctl,
    output lfu_pkg::lfu_status_t     status,
    input  lfu_pkg::req_t            req,
    input  logic [lfu_pkg::CAP_W-1:0] capacity_in_use,
    output lfu_pkg::rsp_t            rsp,
    output logic                     rsp_valid,
    input  logic                     rsp_ready
);
    import lfu_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    // entry storage, read at the scan index or the chosen slot
    logic [KEY_W-1:0]   key_mem   [CAPACITY];
    logic [VAL_W-1:0]   value_mem [CAPACITY];
    logic [COUNT_W-1:0] count_mem [CAPACITY];
    logic [STAMP_W-1:0] stamp_mem [CAPACITY];
    logic [CAPACITY-1:0] valid_reg;

    req_t               req_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   found_idx_reg;
    logic               vic_ok_reg;
    logic [IDX_W-1:0]   vic_idx_reg;
    logic [COUNT_W-1:0] vic_count_reg;
    logic [STAMP_W-1:0] vic_stamp_reg;
    logic               free_ok_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic [OCC_W-1:0]   occ_reg;
    rsp_t               rsp_reg;
    logic               rsp_valid_reg;

    logic               e_valid;
    logic               better;
    logic [CMP_W-1:0]   cap_eff;
    logic               full;
    logic               do_insert;
    logic               do_bump;
    logic               evict;
    logic [IDX_W-1:0]   ins_idx;
    logic [STAMP_W-1:0] stamp_inc;
    logic [COUNT_W-1:0] hit_count;

    assign e_valid = valid_reg[idx_reg];
    assign better = !vic_ok_reg || (count_mem[idx_reg] < vic_count_reg)
        || ((count_mem[idx_reg] == vic_count_reg) && (stamp_mem[idx_reg] < vic_stamp_reg));

    assign status.scan_last = (idx_reg == IDX_W'(CAPACITY - 1));
    assign status.rsp_full  = rsp_valid_reg;

    assign cap_eff = (CMP_W'(capacity_in_use) > CMP_W'(CAPACITY)) ?
        CMP_W'(CAPACITY) : CMP_W'(capacity_in_use);
    assign full = CMP_W'(occ_reg) >= cap_eff;
    assign do_bump = found_reg && ((req_reg.cmd == CMD_GET) || (cap_eff != '0));
    assign evict = full && vic_ok_reg;
    assign do_insert = (req_reg.cmd == CMD_SET) && (cap_eff != '0) && !found_reg
        && (evict || free_ok_reg);
    assign ins_idx = evict ? vic_idx_reg : free_idx_reg;
    assign stamp_inc = stamp_reg + STAMP_W'(1);
    assign hit_count = count_mem[found_idx_reg];

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            req_reg <= req;
        if (ctl.scan && e_valid && better)
        begin
            vic_count_reg <= count_mem[idx_reg];
            vic_stamp_reg <= stamp_mem[idx_reg];
            vic_idx_reg   <= idx_reg;
        end
        if (ctl.scan && e_valid && !found_reg && key_mem[idx_reg] == req_reg.key)
            found_idx_reg <= idx_reg;
        if (ctl.scan && !e_valid && !free_ok_reg)
            free_idx_reg <= idx_reg;
        if (ctl.write && do_bump)
        begin
            if (hit_count != '1)
                count_mem[found_idx_reg] <= hit_count + COUNT_W'(1);
            stamp_mem[found_idx_reg] <= stamp_inc;
            if (req_reg.cmd == CMD_SET)
                value_mem[found_idx_reg] <= req_reg.value;
        end
        if (ctl.write && do_insert)
        begin
            key_mem[ins_idx]   <= req_reg.key;
            value_mem[ins_idx] <= req_reg.value;
            count_mem[ins_idx] <= COUNT_W'(1);
            stamp_mem[ins_idx] <= stamp_inc;
        end
        if (ctl.resp)
        begin
            rsp_reg.hit <= do_bump;
            rsp_reg.read_value <= (do_bump && req_reg.cmd == CMD_GET) ?
                value_mem[found_idx_reg] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            vic_ok_reg    <= 1'b0;
            free_ok_reg   <= 1'b0;
            stamp_reg     <= '0;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load)
            begin
                idx_reg     <= '0;
                found_reg   <= 1'b0;
                vic_ok_reg  <= 1'b0;
                free_ok_reg <= 1'b0;
            end
            if (ctl.scan)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (e_valid)
                    vic_ok_reg <= 1'b1;
                if (e_valid && key_mem[idx_reg] == req_reg.key)
                    found_reg <= 1'b1;
                if (!e_valid)
                    free_ok_reg <= 1'b1;
            end
            if (ctl.write && (do_bump || do_insert))
                stamp_reg <= stamp_inc;
            if (ctl.write && do_insert)
            begin
                valid_reg[ins_idx] <= 1'b1;
                // eviction and insert on the same slot leave occupancy unchanged
                if (!evict)
                    occ_reg <= occ_reg + OCC_W'(1);
            end
            if (ctl.resp)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == OCC_W'($countones(valid_reg)))
        else $error("occupancy disagrees with valid bits");
    a_hit_set_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.resp && req_reg.cmd == CMD_SET |=> rsp_reg.read_value == '0)
        else $error("set returned data");
    a_no_resp_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.resp |-> !rsp_valid_reg || rsp_ready)
        else $error("response overwritten");
endmodule

// File: rtl/lfu_cache_engine.sv
// Fully associative key/value cache with least-frequently-used replacement and
// a least-recently-touched tie break. One request is handled at a time: after
// acceptance the datapath walks all CAPACITY entries, one per cycle, matching
// the key and tracking the victim, then applies the update in a write state.
// The response sits in an output register; a new request is taken once that
// register is free. capacity_in_use is clamped to CAPACITY; zero blocks inserts.
module lfu_cache_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    lfu_req_if.sink                   req,
    lfu_rsp_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata
);
    import lfu_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    lfu_cmd_t         ctl;
    lfu_status_t      status;
    req_t             req_pl;
    rsp_t             rsp_pl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_W'(16);
        else if (cfg_we)
            cap_reg <= cfg_wdata;
    end

    assign req_pl.cmd   = req.cmd;
    assign req_pl.key   = req.key;
    assign req_pl.value = req.value;

    lfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .ctl       (ctl)
    );

    lfu_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .status          (status),
        .req             (req_pl),
        .capacity_in_use (cap_reg),
        .rsp             (rsp_pl),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready)
    );

    assign rsp.hit        = rsp_pl.hit;
    assign rsp.read_value = rsp_pl.read_value;
endmodule

// File: dv/lfu_cache_engine_test.sv
module lfu_cache_engine_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lfu_pkg::*;

    localparam int SLOTS = 16;
    localparam int LATENCY = SLOTS + 2;

    typedef struct {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } lookup_t;

    class lfu_scoreboard;
        logic [CAP_W-1:0]   capacity;
        logic               slot_valid [SLOTS];
        logic [KEY_W-1:0]   slot_key [SLOTS];
        logic [VAL_W-1:0]   slot_value [SLOTS];
        logic [COUNT_W-1:0] slot_count [SLOTS];
        logic [STAMP_W-1:0] slot_stamp [SLOTS];
        logic [STAMP_W-1:0] stamp_now;
        int                 occupied;
        lookup_t            pending_lookups [$];
        int                 errors;

        function new();
            capacity = 5'd16;
            stamp_now = '0;
            occupied = 0;
            errors = 0;
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        endfunction

        function logic [STAMP_W-1:0] fresh_stamp();
            stamp_now = stamp_now + 1'b1;
            return stamp_now;
        endfunction

        function void touch(int s);
            if (slot_count[s] != '1)
                slot_count[s] = slot_count[s] + 1'b1;
            slot_stamp[s] = fresh_stamp();
        endfunction

        function void note_request(logic cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
            int      s;
            int      cap;
            int      victim;
            lookup_t r;
            s = -1;
            victim = -1;
            cap = (capacity > SLOTS) ? SLOTS : int'(capacity);
            r.hit = 1'b0;
            r.read_value = '0;
            for (int i = 0; i < SLOTS; i++)
                if (s < 0 && slot_valid[i] && slot_key[i] == k)
                    s = i;
            if (cmd == CMD_GET)
            begin
                if (s >= 0)
                begin
                    touch(s);
                    r.hit = 1'b1;
                    r.read_value = slot_value[s];
                end
            end
            else if (cap != 0)
            begin
                if (s >= 0)
                begin
                    slot_value[s] = v;
                    touch(s);
                    r.hit = 1'b1;
                end
                else
                begin
                    if (occupied >= cap)
                    begin
                        // lowest count, oldest stamp breaks the tie
                        for (int i = 0; i < SLOTS; i++)
                            if (slot_valid[i] && (victim < 0 ||
                                slot_count[i] < slot_count[victim] ||
                                (slot_count[i] == slot_count[victim] &&
                                 slot_stamp[i] < slot_stamp[victim])))
                                victim = i;
                        if (victim >= 0)
                        begin
                            slot_valid[victim] = 1'b0;
                            occupied--;
                            s = victim;
                        end
                    end
                    if (s < 0)
                        for (int i = 0; i < SLOTS; i++)
                            if (s < 0 && !slot_valid[i])
                                s = i;
                    if (s >= 0)
                    begin
                        slot_valid[s] = 1'b1;
                        slot_key[s] = k;
                        slot_value[s] = v;
                        slot_count[s] = 1;
                        slot_stamp[s] = fresh_stamp();
                        occupied++;
                    end
                end
            end
            pending_lookups.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_response(logic hit, logic [VAL_W-1:0] rv);
            lookup_t e;
            if (pending_lookups.size() == 0)
                report("response with no request outstanding");
            else
            begin
                e = pending_lookups.pop_front();
                if (hit !== e.hit)
                    report($sformatf("hit %b expected %b", hit, e.hit));
                if (rv !== e.read_value)
                    report($sformatf("read_value %h expected %h", rv, e.read_value));
            end
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;
    int               idle_pct = 0;
    int               stall_pct = 0;
    logic [KEY_W-1:0] key_pool [24];
    lfu_scoreboard    sb;

    lfu_req_if req ();
    lfu_rsp_if rsp ();

    lfu_cache_engine #(.CAPACITY(SLOTS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #10 clk = ~clk;

    initial
    begin
        req.valid = 1'b0;
        req.cmd = CMD_GET;
        req.key = '0;
        req.value = '0;
        rsp.ready = 1'b0;
    end

    always @(posedge clk)
        rsp.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_response(rsp.hit, rsp.read_value);

    task send_request(logic cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        if ($urandom_range(99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd <= cmd;
        req.key <= k;
        req.value <= v;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_request(cmd, k, v);
    endtask

    task wait_drained();
        req.valid <= 1'b0;
        while (sb.pending_lookups.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task set_capacity(logic [CAP_W-1:0] c);
        cfg_we <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.capacity = c;
        @(posedge clk);
    endtask

    function logic [KEY_W-1:0] pick_key();
        if ($urandom_range(9) < 8)
            return key_pool[$urandom_range(23)];
        return $urandom;
    endfunction

    task random_burst(int n);
        for (int i = 0; i < n; i++)
        begin
            // hold off once mid-burst until the cache is quiet
            if (i == n / 2)
            begin
                req.valid <= 1'b0;
                while (sb.pending_lookups.size() != 0)
                    @(posedge clk);
            end
            send_request(logic'($urandom_range(1)), pick_key(), $urandom);
        end
    endtask

    initial
    begin
        int caps [8];
        int idles [8];
        int stalls [8];
        sb = new();
        caps = '{16, 1, 0, 31, 5, 2, 16, 8};
        idles = '{0, 73, 0, 30, 0, 73, 30, 0};
        stalls = '{0, 0, 73, 30, 73, 0, 30, 0};
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hffff_ffff;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7fff_ffff;
        for (int i = 4; i < 24; i++)
            key_pool[i] = $urandom;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset capacity: get miss, set fill, update, get hit
        send_request(CMD_GET, 32'h8000_0000, 32'h1234_5678);
        send_request(CMD_SET, 32'h8000_0000, 32'h7fff_ffff);
        send_request(CMD_SET, 32'h7fff_ffff, 32'h8000_0000);
        send_request(CMD_SET, 32'h0000_0000, 32'hffff_ffff);
        send_request(CMD_SET, 32'hffff_ffff, 32'h0000_0000);
        send_request(CMD_GET, 32'h8000_0000, 32'h0);
        send_request(CMD_SET, 32'h7fff_ffff, 32'h5555_aaaa);
        send_request(CMD_GET, 32'h7fff_ffff, 32'hffff_ffff);
        send_request(CMD_GET, 32'hffff_ffff, 32'h0);
        wait_drained();
        // shrink below occupancy: each set miss evicts one, lfu then oldest
        set_capacity(5'd2);
        send_request(CMD_SET, 32'h0000_1111, 32'h1);
        send_request(CMD_SET, 32'h0000_2222, 32'h2);
        send_request(CMD_GET, 32'h0000_0000, 32'h0);
        send_request(CMD_GET, 32'h0000_2222, 32'h0);
        wait_drained();
        // zero capacity: sets ignored, gets still hit
        set_capacity(5'd0);
        send_request(CMD_SET, 32'h0000_3333, 32'h3);
        send_request(CMD_GET, 32'h0000_3333, 32'h0);
        send_request(CMD_SET, 32'h0000_2222, 32'h9);
        send_request(CMD_GET, 32'h0000_2222, 32'h0);
        wait_drained();
        // above the slot count clamps
        set_capacity(5'd31);
        for (int i = 0; i < 4; i++)
            send_request(CMD_SET, key_pool[4 + i], $urandom);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            idle_pct = idles[p];
            stall_pct = stalls[p];
            set_capacity(caps[p][CAP_W-1:0]);
            random_burst(160);
            wait_drained();
        end
        idle_pct = 0;
        stall_pct = 0;
        random_burst(20);
        wait_drained();

        if (sb.errors == 0 && sb.pending_lookups.size() == 0)
            $display("PASS lfu_cache_engine");
        else
            $display("FAIL lfu_cache_engine");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL lfu_cache_engine");
        $finish;
    end
endmodule

// File: lfu_cache_engine.f
rtl/lfu_pkg.sv
rtl/lfu_if.sv
rtl/lfu_ctrl.sv
rtl/lfu_datapath.sv
rtl/lfu_cache_engine.sv
dv/lfu_cache_engine_test.sv
